### hdl/rair_pkg.sv
// Shared constants and types for the ray / axis-aligned rectangle intersection block.
`default_nettype none

package rair_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int UV_BITS        = 16;
    localparam int CFG_IDX_W      = 3;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THIN_AXIS = 3'd0,
        CFG_PLANE_POS = 3'd1,
        CFG_LO_A      = 3'd2,
        CFG_HI_A      = 3'd3,
        CFG_LO_B      = 3'd4,
        CFG_HI_B      = 3'd5
    } cfg_idx_t;

endpackage

`default_nettype wire

### hdl/rair_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none

module rair_div #(
    parameter int DW = rair_pkg::WORD_WIDTH_DEF,
    parameter int QB = rair_pkg::WORD_WIDTH_DEF - 1,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          en,
    input  wire logic          vld_in,
    input  wire logic [DW-1:0] r_in,
    input  wire logic [DW-1:0] d_in,
    input  wire logic [QB-1:0] feed_in,
    input  wire logic [SW-1:0] side_in,
    output logic               vld_out,
    output logic [QB-1:0]      q_out,
    output logic [SW-1:0]      side_out
);

    logic          vld_reg  [QB];
    logic [DW-1:0] r_reg    [QB];
    logic [DW-1:0] d_reg    [QB];
    logic [QB-1:0] q_reg    [QB];
    logic [QB-1:0] feed_reg [QB];
    logic [SW-1:0] side_reg [QB];

    for (genvar k = 0; k < QB; k++) begin : g_step
        logic          vld_prev;
        logic [DW-1:0] r_prev;
        logic [DW-1:0] d_prev;
        logic [QB-1:0] q_prev;
        logic [QB-1:0] feed_prev;
        logic [SW-1:0] side_prev;
        logic [DW:0]   rs;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] r_next;
        logic [QB-1:0] q_next;

        if (k == 0) begin : g_first
            assign vld_prev  = vld_in;
            assign r_prev    = r_in;
            assign d_prev    = d_in;
            assign q_prev    = '0;
            assign feed_prev = feed_in;
            assign side_prev = side_in;
        end
        else begin : g_rest
            assign vld_prev  = vld_reg[k-1];
            assign r_prev    = r_reg[k-1];
            assign d_prev    = d_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign feed_prev = feed_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        always_comb
        begin
            rs     = {r_prev, feed_prev[QB-1-k]};
            diff   = rs - {1'b0, d_prev};
            ge     = (rs >= {1'b0, d_prev});
            r_next = ge ? diff[DW-1:0] : rs[DW-1:0];
            q_next = q_prev;
            q_next[QB-1-k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]    <= r_next;
                d_reg[k]    <= d_prev;
                q_reg[k]    <= q_next;
                feed_reg[k] <= feed_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign vld_out  = vld_reg[QB-1];
    assign q_out    = q_reg[QB-1];
    assign side_out = side_reg[QB-1];

endmodule

`default_nettype wire

### hdl/ray_axis_aligned_rect_intersect.sv
// Throughput: one word per cycle; the hit-time divider and the u/v dividers are
// pipelined at one quotient bit per stage, the three products take one stage.
// A stall at the output holds every stage and drops tready on the input.
// Reset (rst_n, asynchronous) empties the pipeline and loads the default rectangle.
`default_nettype none

module ray_axis_aligned_rect_intersect #(
    parameter int WORD_WIDTH = rair_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = rair_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // s_tdata: org_x, org_y, org_z, dir_x, dir_y, dir_z, t_lo, t_hi
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [8*WORD_WIDTH-1:0]             s_tdata,
    // m_tdata: hit, t_hit, pt_x, pt_y, pt_z, tex_u, tex_v, front_face, zero pad
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [((4*WORD_WIDTH+2*(rair_pkg::UV_BITS+1)+2+7)/8)*8-1:0] m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [rair_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [WORD_WIDTH-1:0]               cfg_data
);

    localparam int W      = WORD_WIDTH;
    localparam int F      = FRAC_BITS;
    localparam int UVB    = rair_pkg::UV_BITS;
    localparam int TW     = UVB + 1;
    localparam int PW     = 2 * W + 2;
    localparam int OUT_W  = ((4 * W + 2 * TW + 2 + 7) / 8) * 8;
    localparam int TSIDE  = 8 * W + 4;
    localparam int USIDE  = 4 * W + 3;
    localparam logic signed [PW-1:0] P_MAX = {{(W + 3){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [PW-1:0] P_MIN = {{(W + 3){1'b1}}, {(W - 1){1'b0}}};

    // configuration
    rair_pkg::axis_t thin_axis_reg;
    logic [W-1:0]    plane_pos_reg;
    logic [W-1:0]    lo_a_reg;
    logic [W-1:0]    hi_a_reg;
    logic [W-1:0]    lo_b_reg;
    logic [W-1:0]    hi_b_reg;

    logic en;
    logic out_vld_reg;
    logic [OUT_W-1:0] out_data_reg;

    assign cfg_ready = 1'b1;
    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign m_tvalid  = out_vld_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thin_axis_reg <= rair_pkg::AXIS_Z;
            plane_pos_reg <= '0;
            lo_a_reg      <= '0;
            hi_a_reg      <= W'(1) << F;
            lo_b_reg      <= '0;
            hi_b_reg      <= W'(1) << F;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (rair_pkg::cfg_idx_t'(cfg_index))
                rair_pkg::CFG_THIN_AXIS: thin_axis_reg <= rair_pkg::axis_t'(cfg_data[1:0]);
                rair_pkg::CFG_PLANE_POS: plane_pos_reg <= cfg_data;
                rair_pkg::CFG_LO_A:      lo_a_reg      <= cfg_data;
                rair_pkg::CFG_HI_A:      hi_a_reg      <= cfg_data;
                rair_pkg::CFG_LO_B:      lo_b_reg      <= cfg_data;
                rair_pkg::CFG_HI_B:      hi_b_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage 1: input word
    logic           p1_vld_reg;
    logic [8*W-1:0] p1_data_reg;

    // stage 2: numerator of the hit time
    logic           p2_vld_reg;
    logic [8*W-1:0] p2_data_reg;
    logic [W:0]     p2_num_reg;
    logic [W-1:0]   p2_dth_reg;
    logic [W-1:0]   o_thin;
    logic [W-1:0]   d_thin;
    logic [W:0]     num_next;

    always_comb
    begin
        case (thin_axis_reg)
            rair_pkg::AXIS_X:
            begin
                o_thin = p1_data_reg[0 +: W];
                d_thin = p1_data_reg[3*W +: W];
            end
            rair_pkg::AXIS_Y:
            begin
                o_thin = p1_data_reg[W +: W];
                d_thin = p1_data_reg[4*W +: W];
            end
            default:
            begin
                o_thin = p1_data_reg[2*W +: W];
                d_thin = p1_data_reg[5*W +: W];
            end
        endcase
        num_next = {plane_pos_reg[W-1], plane_pos_reg} - {o_thin[W-1], o_thin};
    end

    // stage 3: magnitudes, overflow check, divider seed
    logic           p3_vld_reg;
    logic [8*W-1:0] p3_data_reg;
    logic [W-1:0]   p3_r_reg;
    logic [W-2:0]   p3_feed_reg;
    logic [W-1:0]   p3_d_reg;
    logic           p3_neg_reg;
    logic           p3_dz_reg;
    logic           p3_ovf_reg;
    logic           p3_ff_reg;
    logic [W:0]     num_abs;
    logic [W-1:0]   mag_num;
    logic [W-1:0]   mag_d;
    logic [W+F-1:0] dvd;
    logic [W+F-1:0] dvd_top;
    logic           ovf_next;

    always_comb
    begin
        num_abs  = p2_num_reg[W] ? (~p2_num_reg + 1'b1) : p2_num_reg;
        mag_num  = num_abs[W-1:0];
        mag_d    = p2_dth_reg[W-1] ? (~p2_dth_reg + 1'b1) : p2_dth_reg;
        dvd      = {mag_num, {F{1'b0}}};
        dvd_top  = dvd >> (W - 1);
        // quotient would need W or more bits: saturate
        ovf_next = (dvd_top >= (W + F)'(mag_d));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_vld_reg <= s_tvalid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_data_reg <= s_tdata;
            p2_data_reg <= p1_data_reg;
            p2_num_reg  <= num_next;
            p2_dth_reg  <= d_thin;
            p3_data_reg <= p2_data_reg;
            p3_r_reg    <= dvd_top[W-1:0];
            p3_feed_reg <= dvd[W-2:0];
            p3_d_reg    <= mag_d;
            p3_neg_reg  <= p2_num_reg[W] ^ p2_dth_reg[W-1];
            p3_dz_reg   <= (p2_dth_reg == '0);
            p3_ovf_reg  <= ovf_next;
            p3_ff_reg   <= p2_dth_reg[W-1];
        end
    end

    // hit time divider
    logic             tdv_vld;
    logic [W-2:0]     tdv_q;
    logic [TSIDE-1:0] tdv_side;

    rair_div #(
        .DW(W),
        .QB(W - 1),
        .SW(TSIDE)
    ) u_tdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (p3_vld_reg),
        .r_in     (p3_r_reg),
        .d_in     (p3_d_reg),
        .feed_in  (p3_feed_reg),
        .side_in  ({p3_data_reg, p3_neg_reg, p3_dz_reg, p3_ovf_reg, p3_ff_reg}),
        .vld_out  (tdv_vld),
        .q_out    (tdv_q),
        .side_out (tdv_side)
    );

    // stage 4: signed, saturated time and window test
    logic [8*W-1:0] td_data;
    logic           td_neg;
    logic           td_dz;
    logic           td_ovf;
    logic           td_ff;
    logic [W-1:0]   q_lim;
    logic [W-1:0]   q_sat;
    logic [W-1:0]   t_next;
    logic           win_next;

    always_comb
    begin
        td_data  = tdv_side[TSIDE-1:4];
        td_neg   = tdv_side[3];
        td_dz    = tdv_side[2];
        td_ovf   = tdv_side[1];
        td_ff    = tdv_side[0];
        q_lim    = td_neg ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
        q_sat    = td_ovf ? q_lim : {1'b0, tdv_q};
        t_next   = td_neg ? (~q_sat + 1'b1) : q_sat;
        win_next = !td_dz
                   && ($signed(t_next) >= $signed(td_data[6*W +: W]))
                   && ($signed(t_next) <= $signed(td_data[7*W +: W]));
    end

    logic         p4_vld_reg;
    logic [W-1:0] p4_o_reg [3];
    logic [W-1:0] p4_d_reg [3];
    logic [W-1:0] p4_t_reg;
    logic         p4_win_reg;
    logic         p4_ff_reg;

    // stage 5: products t * dir
    logic                  p5_vld_reg;
    logic [W-1:0]          p5_o_reg [3];
    logic signed [2*W-1:0] p5_prod_reg [3];
    logic [W-1:0]          p5_t_reg;
    logic                  p5_win_reg;
    logic                  p5_ff_reg;

    // stage 6: hit point, full precision
    logic                 p6_vld_reg;
    logic signed [PW-1:0] p6_sum_reg [3];
    logic [W-1:0]         p6_t_reg;
    logic                 p6_win_reg;
    logic                 p6_ff_reg;
    logic signed [2*W-1:0] prod_sh [3];
    logic signed [PW-1:0]  sum_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // arithmetic shift rounds toward minus infinity
            prod_sh[i]  = p5_prod_reg[i] >>> F;
            sum_next[i] = $signed({{(W + 2){p5_o_reg[i][W-1]}}, p5_o_reg[i]})
                          + $signed({{2{prod_sh[i][2*W-1]}}, prod_sh[i]});
        end
    end

    // stage 7: bounds, saturation, u/v seeds
    logic         p7_vld_reg;
    logic         p7_hit_reg;
    logic [W-1:0] p7_t_reg;
    logic [W-1:0] p7_pt_reg [3];
    logic         p7_ff_reg;
    logic [W-1:0] p7_nu_reg;
    logic [W-1:0] p7_nv_reg;
    logic [W-1:0] p7_du_reg;
    logic [W-1:0] p7_dv_reg;
    logic         p7_gu_reg;
    logic         p7_gv_reg;

    logic signed [PW-1:0] pa;
    logic signed [PW-1:0] pb;
    logic signed [PW-1:0] lo_a_x;
    logic signed [PW-1:0] hi_a_x;
    logic signed [PW-1:0] lo_b_x;
    logic signed [PW-1:0] hi_b_x;
    logic                 hit_next;
    logic [W-1:0]         pt_sat [3];

    always_comb
    begin
        case (thin_axis_reg)
            rair_pkg::AXIS_X:
            begin
                pa = p6_sum_reg[1];
                pb = p6_sum_reg[2];
            end
            rair_pkg::AXIS_Y:
            begin
                pa = p6_sum_reg[0];
                pb = p6_sum_reg[2];
            end
            default:
            begin
                pa = p6_sum_reg[0];
                pb = p6_sum_reg[1];
            end
        endcase
        lo_a_x   = $signed({{(W + 2){lo_a_reg[W-1]}}, lo_a_reg});
        hi_a_x   = $signed({{(W + 2){hi_a_reg[W-1]}}, hi_a_reg});
        lo_b_x   = $signed({{(W + 2){lo_b_reg[W-1]}}, lo_b_reg});
        hi_b_x   = $signed({{(W + 2){hi_b_reg[W-1]}}, hi_b_reg});
        hit_next = p6_win_reg && (pa >= lo_a_x) && (pa <= hi_a_x)
                   && (pb >= lo_b_x) && (pb <= hi_b_x);
        for (int i = 0; i < 3; i++)
        begin
            if (p6_sum_reg[i] > P_MAX)
                pt_sat[i] = P_MAX[W-1:0];
            else if (p6_sum_reg[i] < P_MIN)
                pt_sat[i] = P_MIN[W-1:0];
            else
                pt_sat[i] = p6_sum_reg[i][W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
            p6_vld_reg <= 1'b0;
            p7_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p4_vld_reg <= tdv_vld;
            p5_vld_reg <= p4_vld_reg;
            p6_vld_reg <= p5_vld_reg;
            p7_vld_reg <= p6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p4_o_reg[i]    <= td_data[i*W +: W];
                p4_d_reg[i]    <= td_data[(3+i)*W +: W];
                p5_o_reg[i]    <= p4_o_reg[i];
                p5_prod_reg[i] <= $signed(p4_t_reg) * $signed(p4_d_reg[i]);
                p6_sum_reg[i]  <= sum_next[i];
                // a miss returns an all-zero word
                p7_pt_reg[i]   <= hit_next ? pt_sat[i] : '0;
            end
            p4_t_reg   <= t_next;
            p4_win_reg <= win_next;
            p4_ff_reg  <= td_ff;
            p5_t_reg   <= p4_t_reg;
            p5_win_reg <= p4_win_reg;
            p5_ff_reg  <= p4_ff_reg;
            p6_t_reg   <= p5_t_reg;
            p6_win_reg <= p5_win_reg;
            p6_ff_reg  <= p5_ff_reg;
            p7_hit_reg <= hit_next;
            p7_t_reg   <= hit_next ? p6_t_reg : '0;
            p7_ff_reg  <= hit_next && p6_ff_reg;
            p7_nu_reg  <= pa[W-1:0] - lo_a_reg;
            p7_nv_reg  <= pb[W-1:0] - lo_b_reg;
            p7_du_reg  <= hi_a_reg - lo_a_reg;
            p7_dv_reg  <= hi_b_reg - lo_b_reg;
            p7_gu_reg  <= !($signed(hi_a_reg) > $signed(lo_a_reg));
            p7_gv_reg  <= !($signed(hi_b_reg) > $signed(lo_b_reg));
        end
    end

    // u and v dividers
    logic             udv_vld;
    logic [TW-1:0]    udv_q;
    logic [USIDE-1:0] udv_side;
    logic             vdv_vld;
    logic [TW-1:0]    vdv_q;
    logic             vdv_side;

    rair_div #(
        .DW(W),
        .QB(TW),
        .SW(USIDE)
    ) u_udiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (p7_vld_reg),
        .r_in     ({1'b0, p7_nu_reg[W-1:1]}),
        .d_in     (p7_du_reg),
        .feed_in  ({p7_nu_reg[0], {UVB{1'b0}}}),
        .side_in  ({p7_hit_reg, p7_t_reg, p7_pt_reg[0], p7_pt_reg[1], p7_pt_reg[2],
                    p7_ff_reg, p7_gu_reg}),
        .vld_out  (udv_vld),
        .q_out    (udv_q),
        .side_out (udv_side)
    );

    rair_div #(
        .DW(W),
        .QB(TW),
        .SW(1)
    ) u_vdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (p7_vld_reg),
        .r_in     ({1'b0, p7_nv_reg[W-1:1]}),
        .d_in     (p7_dv_reg),
        .feed_in  ({p7_nv_reg[0], {UVB{1'b0}}}),
        .side_in  (p7_gv_reg),
        .vld_out  (vdv_vld),
        .q_out    (vdv_q),
        .side_out (vdv_side)
    );

    // output word
    logic          o_hit;
    logic [W-1:0]  o_t;
    logic [W-1:0]  o_px;
    logic [W-1:0]  o_py;
    logic [W-1:0]  o_pz;
    logic          o_ff;
    logic          o_gu;
    logic [TW-1:0] o_u;
    logic [TW-1:0] o_v;

    always_comb
    begin
        o_hit = udv_side[USIDE-1];
        o_t   = udv_side[3*W+2 +: W];
        o_px  = udv_side[2*W+2 +: W];
        o_py  = udv_side[W+2 +: W];
        o_pz  = udv_side[2 +: W];
        o_ff  = udv_side[1];
        o_gu  = udv_side[0];
        // empty or inverted span, or a miss, gives zero
        o_u   = (o_hit && !o_gu) ? udv_q : '0;
        o_v   = (o_hit && !vdv_side) ? vdv_q : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= udv_vld && vdv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= OUT_W'({o_ff, o_v, o_u, o_pz, o_py, o_px, o_t, o_hit});
        end
    end

endmodule

`default_nettype wire

### hdl/rair_chk.sv
// Port-level checker for the ray / rectangle intersection block, bound to the top level.
`default_nettype none

module rair_chk #(
    parameter int WORD_WIDTH = rair_pkg::WORD_WIDTH_DEF
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((4*WORD_WIDTH+2*(rair_pkg::UV_BITS+1)+2+7)/8)*8-1:0] m_tdata,
    input wire logic cfg_valid,
    input wire logic cfg_ready
);

    localparam int W   = WORD_WIDTH;
    localparam int TW  = rair_pkg::UV_BITS + 1;
    localparam logic [TW-1:0] UV_ONE = TW'(1) << rair_pkg::UV_BITS;

    // a held output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // a blocked output stalls the whole pipe, input included
    a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // a miss carries nothing but zeros
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata == '0)
        else $error("miss word not zero");

    a_uv_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4*W+1 +: TW] <= UV_ONE) && (m_tdata[4*W+1+TW +: TW] <= UV_ONE))
        else $error("u or v beyond one");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind ray_axis_aligned_rect_intersect rair_chk #(.WORD_WIDTH(WORD_WIDTH)) u_rair_chk (.*);

`default_nettype wire
